// ----- rtl/core/bm3_pkg.sv -----
// Package for the 3x3 binary morphology block: sizes, register indexes, reset values.
// No dependencies; imported by binary_morphology_3x3.
`default_nettype none

package bm3_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned AddrW     = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned DimW      = 11;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [DimW-1:0] DimMin      = DimW'(3);
  localparam logic [DimW-1:0] WidthMax    = DimW'(MaxWidth);
  localparam logic [DimW-1:0] HeightMax   = DimW'(MaxHeight);
  localparam logic [DimW-1:0] WidthReset  = DimW'(640);
  localparam logic [DimW-1:0] HeightReset = DimW'(480);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_DILATE = 1'b0,
    MODE_ERODE  = 1'b1
  } morph_mode_e;

  // Limit a written dimension to 3 .. hi.
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] hi);
    logic [DimW-1:0] r;
    if (v < DimMin) begin
      r = DimMin;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/binary_morphology_3x3.sv -----
// 3x3 binary dilation / erosion over a raster pixel stream.
// Depends on bm3_pkg (sizes, register indexes, clamp function).
`default_nettype none

// Usage
//   Slave stream: one binary pixel per item in raster order (row by row, left to
//   right). Master stream: one item per interior pixel (not first/last row or
//   column) carrying the 3x3 result for that pixel plus its row and column;
//   tlast marks the last interior pixel of the frame.
//   Config port: write mode (0 dilate, 1 erode), image_width, image_height
//   while the block is idle; dimensions are clamped to 3 .. 1024.
//   Path: after its pixel is accepted, a result passes the middle stage (the
//   line-store read is registered there together with the pixel), then the
//   output register.
//   Throughput: one pixel per cycle while the receiver does not stall, set by
//   the line store doing one read and one write per cycle (read at accept,
//   write-back at the same column when the item leaves the middle stage).
//   Reset: counters, window and config registers clear (mode dilate, 640x480);
//   line-store contents stay undefined until written by the first two rows.
//   Stall: when the receiver holds tready low with a result pending, the
//   middle stage holds, and so does the input side once that stage is full;
//   slave tready drops only while output register and middle stage are full.
module binary_morphology_3x3
  import bm3_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [DimW-1:0]     cfg_data_i,
  // pixel input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [0] pixel_in, [7:1] zero
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [23:0]              m_axis_tdata,   // [0] pixel_out, [10:1] out_row,
                                                   // [20:11] out_col, [23:21] zero
  output logic                     m_axis_tlast    // frame_last
);

  // configuration registers
  logic            mode_q;
  logic [DimW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_DILATE;
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   mode_q   <= cfg_data_i[0];
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [DimW-1:0] w_eff, h_eff;
  assign w_eff = clamp_dim(width_q, WidthMax);
  assign h_eff = clamp_dim(height_q, HeightMax);

  // handshake and pipeline control
  logic out_valid_q;
  logic s1_valid_q;
  logic stall, accept, s1_adv;

  assign stall         = out_valid_q && !m_axis_tready;
  assign s_axis_tready = !(s1_valid_q && stall);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s1_adv        = s1_valid_q && !stall;

  // position counters of the incoming pixel
  logic [AddrW-1:0] col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             col_end, row_end;

  assign col_end = {1'b0, col_q} >= (w_eff - DimW'(1));
  assign row_end = {1'b0, row_q} >= (h_eff - DimW'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line store: bit 0 row above, bit 1 two rows above; read at accept,
  // written back by the middle stage at the same column
  logic [1:0]       line_mem [MaxWidth];
  logic [1:0]       rd_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_px_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_adv) begin
      line_mem[s1_addr_q] <= {rd_q[0], s1_px_q};
    end
  end

  // middle stage payload: emit decision and position, taken at accept
  logic             s1_emit_q, s1_last_q;
  logic [RowW-1:0]  s1_row_q;
  logic [AddrW-1:0] s1_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= s_axis_tdata[0];
      s1_addr_q <= col_q;
      s1_emit_q <= (row_q >= RowW'(2)) && (col_q >= AddrW'(2));
      s1_last_q <= row_end && col_end;
      s1_row_q  <= row_q - RowW'(1);
      s1_col_q  <= col_q - AddrW'(1);
    end
  end

  // 3x3 window, newest column in the low bits
  logic [8:0] window_q, window_d;
  logic       res;

  assign window_d = {window_q[5:0], rd_q[1], rd_q[0], s1_px_q};

  always_comb begin
    if (mode_q == MODE_ERODE) begin
      res = &window_d;
    end else begin
      res = |window_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (s1_adv) begin
      window_q <= window_d;
    end
  end

  // output register
  logic             out_px_q, out_last_q;
  logic [RowW-1:0]  out_row_q;
  logic [AddrW-1:0] out_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!stall) begin
      out_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      out_px_q   <= res;
      out_row_q  <= s1_row_q;
      out_col_q  <= s1_col_q;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_col_q, out_row_q, out_px_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
